@@ design/pbsm_pkg.sv @@
package pbsm_pkg;

    // Geometry of the slot ring and of the fields around it.
    localparam int SLOT_BITS   = 10;
    localparam int HANDLE_BITS = 16;
    localparam int ID_BITS     = 32;
    localparam int TIME_BITS   = 32;
    localparam int HOLD_BITS   = 8;
    localparam int NSLOTS      = 1 << SLOT_BITS;
    localparam int COOKIE_BITS = ID_BITS - SLOT_BITS;
    localparam int FILL_BITS   = SLOT_BITS + 1;

    localparam logic [COOKIE_BITS-1:0] COOKIE_ONES = '1;
    localparam logic [ID_BITS-1:0]     NO_ID       = '1;
    localparam logic [TIME_BITS-1:0]   TIME_MAX    = '1;
    localparam logic [HOLD_BITS-1:0]   HOLD_RESET  = HOLD_BITS'(1);

    // Operation codes on the opcode field.
    localparam logic [2:0] OP_SAVE     = 3'd0;
    localparam logic [2:0] OP_RETRIEVE = 3'd1;
    localparam logic [2:0] OP_VERIFY   = 3'd2;
    localparam logic [2:0] OP_IS_ALIVE = 3'd3;
    localparam logic [2:0] OP_DISCARD  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SAVE
    } state_t;

    // One slot as held in the slot memory.
    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic                   full;
        logic [COOKIE_BITS-1:0] cookie;
        logic [TIME_BITS-1:0]   expiry;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic read_next;
        logic finish_id;
        logic finish_save;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic save_op;
        logic save_keep;
        logic out_free;
    } stat_t;

endpackage

@@ design/pbsm_ram.sv @@
module pbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/pbsm_ctrl.sv @@
module pbsm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pbsm_pkg::stat_t stat,
    output pbsm_pkg::cmd_t  cmd
);

    pbsm_pkg::state_t state_reg;
    pbsm_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbsm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pbsm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = pbsm_pkg::S_CHECK;
                end
            end
            pbsm_pkg::S_CHECK:
            begin
                // A save whose id is not alive goes on to the next ring slot.
                if (stat.save_op && !stat.save_keep)
                begin
                    cmd.read_next = 1'b1;
                    state_next    = pbsm_pkg::S_SAVE;
                end
                else if (stat.out_free)
                begin
                    cmd.finish_id = 1'b1;
                    state_next    = pbsm_pkg::S_IDLE;
                end
            end
            pbsm_pkg::S_SAVE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_save = 1'b1;
                    state_next      = pbsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pbsm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ design/pbsm_datapath.sv @@
module pbsm_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [pbsm_pkg::HOLD_BITS-1:0]   hold_seconds,
    input  logic [2:0]                       opcode,
    input  logic [pbsm_pkg::ID_BITS-1:0]     pkt_id,
    input  logic [pbsm_pkg::HANDLE_BITS-1:0] packet_handle,
    input  logic                             destroy_packet,
    input  logic [pbsm_pkg::TIME_BITS-1:0]   now_sec,
    input  pbsm_pkg::cmd_t                   cmd,
    output pbsm_pkg::stat_t                  stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [pbsm_pkg::ID_BITS-1:0]     result_id,
    output logic [pbsm_pkg::HANDLE_BITS-1:0] handle_out,
    output logic                             handle_valid,
    output logic                             alive,
    output logic [pbsm_pkg::HANDLE_BITS-1:0] freed_handle,
    output logic                             freed_valid
);

    localparam int SB = pbsm_pkg::SLOT_BITS;
    localparam int EW = $bits(pbsm_pkg::entry_t);

    // Captured item.
    logic [2:0]                       op_reg;
    logic [pbsm_pkg::ID_BITS-1:0]     id_reg;
    logic [pbsm_pkg::HANDLE_BITS-1:0] handle_reg;
    logic                             destroy_reg;
    logic [pbsm_pkg::TIME_BITS-1:0]   now_reg;

    // Control state of the ring.
    logic [pbsm_pkg::HOLD_BITS-1:0]   hold_reg;
    logic [SB-1:0]                    next_slot_reg;
    logic [pbsm_pkg::FILL_BITS-1:0]   fill_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [1:0]                       status_reg;
    logic [pbsm_pkg::ID_BITS-1:0]     rid_reg;
    logic [pbsm_pkg::HANDLE_BITS-1:0] hout_reg;
    logic                             hvalid_reg;
    logic                             alive_reg;
    logic [pbsm_pkg::HANDLE_BITS-1:0] fh_reg;
    logic                             fvalid_reg;

    // Memory port signals.
    logic                 ram_we;
    logic [SB-1:0]        ram_waddr;
    pbsm_pkg::entry_t     ram_wentry;
    logic                 ram_re;
    logic [SB-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    pbsm_pkg::entry_t     rd;

    // Decoded slot views.
    logic [SB-1:0]                    id_slot;
    logic                             id_valid;
    logic                             id_match;
    logic                             id_alive;
    logic [pbsm_pkg::TIME_BITS-1:0]   id_expiry;
    logic [SB-1:0]                    nxt_slot;
    logic                             nxt_valid;
    logic                             nxt_full;
    logic [pbsm_pkg::TIME_BITS-1:0]   nxt_expiry;
    logic [pbsm_pkg::COOKIE_BITS-1:0] nxt_cookie;
    logic [pbsm_pkg::COOKIE_BITS-1:0] cookie_inc;
    logic [pbsm_pkg::COOKIE_BITS-1:0] cookie_new;
    logic [pbsm_pkg::TIME_BITS:0]     expiry_sum;
    logic [pbsm_pkg::TIME_BITS-1:0]   expiry_new;

    // Result of the finishing step.
    logic [1:0]                       r_status;
    logic [pbsm_pkg::ID_BITS-1:0]     r_rid;
    logic [pbsm_pkg::HANDLE_BITS-1:0] r_hout;
    logic                             r_hvalid;
    logic                             r_alive;
    logic [pbsm_pkg::HANDLE_BITS-1:0] r_fh;
    logic                             r_fvalid;
    logic                             fill_inc;
    logic                             finish;

    pbsm_ram #(
        .WIDTH (EW),
        .DEPTH (pbsm_pkg::NSLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = pbsm_pkg::entry_t'(ram_rdata);

    // Read the id's slot on a transfer, the next ring slot after that.
    assign nxt_slot  = next_slot_reg + SB'(1);
    assign ram_re    = cmd.accept || cmd.read_next;
    assign ram_raddr = cmd.accept ? pkt_id[SB-1:0] : nxt_slot;

    // Slots are first used in ring order, so a slot below the fill count has
    // been written; any other slot reads as never used.
    assign id_slot   = id_reg[SB-1:0];
    assign id_valid  = {1'b0, id_slot} < fill_reg;
    assign id_match  = id_valid && (rd.cookie == id_reg[pbsm_pkg::ID_BITS-1:SB]);
    assign id_expiry = id_valid ? rd.expiry : '0;
    assign id_alive  = id_match && (now_reg < id_expiry);

    assign nxt_valid  = {1'b0, next_slot_reg} < fill_reg;
    assign nxt_full   = nxt_valid && rd.full;
    assign nxt_expiry = nxt_valid ? rd.expiry : '0;
    assign nxt_cookie = nxt_valid ? rd.cookie : pbsm_pkg::COOKIE_ONES;

    // Cookie advances and skips the all-ones value.
    assign cookie_inc = nxt_cookie + pbsm_pkg::COOKIE_BITS'(1);
    assign cookie_new = (cookie_inc == pbsm_pkg::COOKIE_ONES) ? '0 : cookie_inc;

    // Expiry saturates at the top of the time range.
    assign expiry_sum = {1'b0, now_reg} + (pbsm_pkg::TIME_BITS + 1)'(hold_reg);
    assign expiry_new = expiry_sum[pbsm_pkg::TIME_BITS] ? pbsm_pkg::TIME_MAX
                                                          : expiry_sum[pbsm_pkg::TIME_BITS-1:0];

    assign stat.save_op   = (op_reg == pbsm_pkg::OP_SAVE);
    assign stat.save_keep = (id_reg != pbsm_pkg::NO_ID) && id_alive;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign finish = cmd.finish_id || cmd.finish_save;

    // Resolve the item and the slot update.
    always_comb
    begin
        r_status   = pbsm_pkg::ST_OK;
        r_rid      = pbsm_pkg::NO_ID;
        r_hout     = '0;
        r_hvalid   = 1'b0;
        r_alive    = 1'b0;
        r_fh       = '0;
        r_fvalid   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = id_slot;
        ram_wentry = rd;
        fill_inc   = 1'b0;
        if (cmd.finish_save)
        begin
            ram_waddr = next_slot_reg;
            if (nxt_full && (now_reg < nxt_expiry))
            begin
                r_status = pbsm_pkg::ST_NO_FREE;
            end
            else
            begin
                r_fvalid          = nxt_full;
                r_fh              = nxt_full ? rd.handle : '0;
                ram_we            = 1'b1;
                ram_wentry.handle = handle_reg;
                ram_wentry.full   = 1'b1;
                ram_wentry.cookie = cookie_new;
                ram_wentry.expiry = expiry_new;
                r_rid             = {cookie_new, next_slot_reg};
                fill_inc          = !nxt_valid;
            end
        end
        else if (cmd.finish_id)
        begin
            case (op_reg)
                pbsm_pkg::OP_SAVE:
                begin
                    // Only an alive id finishes here; it is handed back as is.
                    r_rid = id_reg;
                end
                pbsm_pkg::OP_RETRIEVE:
                begin
                    if (!id_match)
                    begin
                        r_status = pbsm_pkg::ST_UNKNOWN;
                    end
                    else if (!rd.full)
                    begin
                        r_status = pbsm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r_hout          = rd.handle;
                        r_hvalid        = 1'b1;
                        ram_we          = 1'b1;
                        ram_wentry.full = 1'b0;
                    end
                end
                pbsm_pkg::OP_VERIFY:
                begin
                    if (!id_match)
                    begin
                        r_status = pbsm_pkg::ST_UNKNOWN;
                    end
                    else if (!rd.full)
                    begin
                        r_status = pbsm_pkg::ST_EMPTY;
                    end
                end
                pbsm_pkg::OP_IS_ALIVE:
                begin
                    r_alive = id_alive;
                end
                pbsm_pkg::OP_DISCARD:
                begin
                    if (!id_match)
                    begin
                        r_status = pbsm_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        r_fvalid        = destroy_reg && rd.full;
                        r_fh            = (destroy_reg && rd.full) ? rd.handle : '0;
                        ram_we          = 1'b1;
                        ram_wentry.full = 1'b0;
                    end
                end
                default:
                begin
                    r_status = pbsm_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    // Item capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= opcode;
            id_reg      <= pkt_id;
            handle_reg  <= packet_handle;
            destroy_reg <= destroy_packet;
            now_reg     <= now_sec;
        end
    end

    // Configuration, ring pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= pbsm_pkg::HOLD_RESET;
            next_slot_reg <= '1;
            fill_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                hold_reg <= hold_seconds;
            end
            if (cmd.read_next)
            begin
                next_slot_reg <= nxt_slot;
            end
            if (fill_inc)
            begin
                fill_reg <= fill_reg + pbsm_pkg::FILL_BITS'(1);
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= r_status;
            rid_reg    <= r_rid;
            hout_reg   <= r_hout;
            hvalid_reg <= r_hvalid;
            alive_reg  <= r_alive;
            fh_reg     <= r_fh;
            fvalid_reg <= r_fvalid;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_id    = rid_reg;
    assign handle_out   = hout_reg;
    assign handle_valid = hvalid_reg;
    assign alive        = alive_reg;
    assign freed_handle = fh_reg;
    assign freed_valid  = fvalid_reg;

endmodule

@@ design/packet_buffer_id_slot_manager_unit.sv @@
// Packet buffer id slot manager.
// Input channel in_valid/in_ready carries one operation (opcode, pkt_id,
// packet_handle, destroy_packet, now_sec). Output channel out_valid/out_ready
// returns exactly one result for each input transfer, in order.
// The hold time is written on cfg_valid/cfg_ready with data on hold_seconds;
// cfg_ready is always high and writes are expected only while the block is idle.
// Retrieve, verify, is-alive, discard and a save of a still-alive id register
// their result from the check state; any other save goes on to the save state,
// since the single read port of the slot memory is used first
// for the id's slot and then for the next ring slot. One operation is in flight
// at a time and the input is ready again in the cycle the result is registered,
// so the block takes no new operation before the last one has finished.
// The output register holds a finished result while the receiver stalls, and
// the next operation can be taken in that time; it waits before finishing
// until the held result has been transferred.
// Reset clears the controller, the output valid flag and the fill count, sets
// the ring pointer to the last slot and the hold time to one second. Slots that
// the ring has not reached yet read as never used; no clearing pass is needed.
module packet_buffer_id_slot_manager_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pbsm_pkg::HOLD_BITS-1:0]   hold_seconds,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       opcode,
    input  logic [pbsm_pkg::ID_BITS-1:0]     pkt_id,
    input  logic [pbsm_pkg::HANDLE_BITS-1:0] packet_handle,
    input  logic                             destroy_packet,
    input  logic [pbsm_pkg::TIME_BITS-1:0]   now_sec,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [pbsm_pkg::ID_BITS-1:0]     result_id,
    output logic [pbsm_pkg::HANDLE_BITS-1:0] handle_out,
    output logic                             handle_valid,
    output logic                             alive,
    output logic [pbsm_pkg::HANDLE_BITS-1:0] freed_handle,
    output logic                             freed_valid
);

    pbsm_pkg::cmd_t  cmd;
    pbsm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pbsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbsm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .hold_seconds   (hold_seconds),
        .opcode         (opcode),
        .pkt_id         (pkt_id),
        .packet_handle  (packet_handle),
        .destroy_packet (destroy_packet),
        .now_sec        (now_sec),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_id      (result_id),
        .handle_out     (handle_out),
        .handle_valid   (handle_valid),
        .alive          (alive),
        .freed_handle   (freed_handle),
        .freed_valid    (freed_valid)
    );

endmodule

@@ design/pbsm_checker.sv @@
module pbsm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [1:0]                       status,
    input logic [pbsm_pkg::ID_BITS-1:0]     result_id,
    input logic                             handle_valid,
    input logic                             freed_valid
);

    // A stalled result keeps its status and id.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_id))
        else $error("result changed while stalled");

    // Only one operation is in flight: no input transfer right after another.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an input transfer");

    // A returned or freed handle only comes with an ok status.
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (handle_valid || freed_valid) |-> status == pbsm_pkg::ST_OK)
        else $error("handle reported without ok status");

    // A refused save gives no id.
    a_no_free_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pbsm_pkg::ST_NO_FREE |-> result_id == pbsm_pkg::NO_ID)
        else $error("refused save returned an id");

endmodule

bind packet_buffer_id_slot_manager_unit pbsm_checker u_pbsm_checker (.*);
